/* src/ie2ui_pkg.sv */
// ----------------------------------------------------------------------------
// ie2ui_pkg: shared types and constants
// Event codes, result kinds, key map sizing and stage records used by the
// raw input event translator.
// ----------------------------------------------------------------------------
package ie2ui_pkg;

  // Key map depth and index width
  localparam int unsigned MAP_ENTRIES = 256;
  localparam int unsigned MapIdxW     = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  // Request opcodes
  localparam logic OP_EVENT  = 1'b0;
  localparam logic OP_MAP_WR = 1'b1;

  // Raw event types
  localparam logic [4:0] TYPE_SYNC = 5'd0;
  localparam logic [4:0] TYPE_KEY  = 5'd1;
  localparam logic [4:0] TYPE_REL  = 5'd2;
  localparam logic [4:0] TYPE_ABS  = 5'd3;

  // Button codes
  localparam logic [15:0] MOUSE_LEFT    = 16'h0110;
  localparam logic [15:0] MOUSE_RIGHT   = 16'h0111;
  localparam logic [15:0] MOUSE_MIDDLE  = 16'h0112;
  localparam logic [15:0] TOUCH_CONTACT = 16'h014A;

  // Axis codes
  localparam logic [15:0] AXIS_X = 16'd0;
  localparam logic [15:0] AXIS_Y = 16'd1;

  // Configuration register indexes
  localparam logic CFG_SCREEN_W = 1'b0;
  localparam logic CFG_SCREEN_H = 1'b1;

  localparam logic [15:0] SCREEN_W_RST = 16'd320;
  localparam logic [15:0] SCREEN_H_RST = 16'd240;

  typedef enum logic [2:0] {
    KIND_KEY_DOWN   = 3'd0,
    KIND_KEY_UP     = 3'd1,
    KIND_MOUSE_DOWN = 3'd2,
    KIND_MOUSE_UP   = 3'd3,
    KIND_MOUSE_MOVE = 3'd4,
    KIND_NONE       = 3'd7
  } kind_e;

  // Request held in the processing stage
  typedef struct packed {
    logic        op;
    logic [4:0]  ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
    logic        code_hit;   // code falls inside the key map
  } s1_t;

  // One result
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] key_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } res_t;

endpackage

/* src/ie2ui_if.sv */
// ----------------------------------------------------------------------------
// ie2ui channel interfaces
// Valid/ready channels for raw event requests and for UI event results.
// ----------------------------------------------------------------------------
interface ie2ui_evt_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [4:0]  ev_type;
  logic [15:0] ev_code;
  logic [31:0] ev_value;
  logic [7:0]  map_index;
  logic [15:0] map_value;

  modport source (output valid, op, ev_type, ev_code, ev_value, map_index, map_value,
                  input ready);
  modport sink   (input valid, op, ev_type, ev_code, ev_value, map_index, map_value,
                  output ready);
endinterface

interface ie2ui_ui_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [15:0] key_code;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  modport source (output valid, event_kind, key_code, pos_x, pos_y, input ready);
  modport sink   (input valid, event_kind, key_code, pos_x, pos_y, output ready);
endinterface

/* src/ie2ui_keymap.sv */
// ----------------------------------------------------------------------------
// ie2ui_keymap: key translation table
// Synchronous memory with one write and one registered read per cycle.
// Per-entry valid bits make every entry read as zero right after reset.
// ----------------------------------------------------------------------------
module ie2ui_keymap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [ie2ui_pkg::MapIdxW-1:0] wr_idx_i,
  input  logic [15:0]                  wr_data_i,
  input  logic                         rd_en_i,
  input  logic [ie2ui_pkg::MapIdxW-1:0] rd_idx_i,
  output logic [15:0]                  rd_data_o
);

  logic [15:0] mem_q [ie2ui_pkg::MAP_ENTRIES];
  logic [ie2ui_pkg::MAP_ENTRIES-1:0] vld_q;
  logic [15:0] rd_data_q;
  logic        rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  // never-written entry reads as zero, which the core treats as pass-through
  assign rd_data_o = rd_vld_q ? rd_data_q : 16'd0;

endmodule

/* src/ie2ui_core.sv */
// ----------------------------------------------------------------------------
// ie2ui_core: event processing stage
// Holds cursor and pending state, builds at most one result per request.
// ----------------------------------------------------------------------------
module ie2ui_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             commit_i,    // stage request retires this cycle
  input  ie2ui_pkg::s1_t  s1_i,
  input  logic [15:0]      map_data_i,
  input  logic [15:0]      screen_w_i,
  input  logic [15:0]      screen_h_i,
  output logic             res_vld_o,
  output ie2ui_pkg::res_t res_o
);

  logic signed [31:0] cur_x_q, cur_x_d;
  logic signed [31:0] cur_y_q, cur_y_d;
  ie2ui_pkg::kind_e   pend_q, pend_d;

  logic               is_btn;
  logic               press;
  logic               axis_x, axis_y;
  logic signed [31:0] rel_base;
  logic signed [32:0] rel_sum;
  logic signed [31:0] rel_sat;
  logic [15:0]        clamp_x, clamp_y;
  logic [15:0]        key_xlat;

  assign is_btn = (s1_i.ev_code == ie2ui_pkg::MOUSE_LEFT)   ||
                  (s1_i.ev_code == ie2ui_pkg::MOUSE_RIGHT)  ||
                  (s1_i.ev_code == ie2ui_pkg::MOUSE_MIDDLE) ||
                  (s1_i.ev_code == ie2ui_pkg::TOUCH_CONTACT);
  assign press  = (s1_i.ev_value != 32'd0);
  assign axis_x = (s1_i.ev_code == ie2ui_pkg::AXIS_X);
  assign axis_y = (s1_i.ev_code == ie2ui_pkg::AXIS_Y);

  assign key_xlat = (s1_i.code_hit && (map_data_i != 16'd0)) ? map_data_i : s1_i.ev_code;

  // saturating relative add, one adder shared by both axes
  assign rel_base = axis_x ? cur_x_q : cur_y_q;
  assign rel_sum  = {rel_base[31], rel_base} + {s1_i.ev_value[31], s1_i.ev_value};
  always_comb begin
    if (rel_sum[32] != rel_sum[31]) begin
      rel_sat = rel_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rel_sat = rel_sum[31:0];
    end
  end

  // clamp to 0..screen size
  always_comb begin
    if (cur_x_q[31]) begin
      clamp_x = 16'd0;
    end else if (cur_x_q > $signed({16'd0, screen_w_i})) begin
      clamp_x = screen_w_i;
    end else begin
      clamp_x = cur_x_q[15:0];
    end
    if (cur_y_q[31]) begin
      clamp_y = 16'd0;
    end else if (cur_y_q > $signed({16'd0, screen_h_i})) begin
      clamp_y = screen_h_i;
    end else begin
      clamp_y = cur_y_q[15:0];
    end
  end

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    pend_d    = pend_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (s1_i.op == ie2ui_pkg::OP_EVENT) begin
      unique case (s1_i.ev_type)
        ie2ui_pkg::TYPE_KEY: begin
          if (is_btn) begin
            pend_d = press ? ie2ui_pkg::KIND_MOUSE_DOWN : ie2ui_pkg::KIND_MOUSE_UP;
          end else begin
            pend_d           = ie2ui_pkg::KIND_NONE;
            res_vld_o        = 1'b1;
            res_o.event_kind = press ? ie2ui_pkg::KIND_KEY_DOWN : ie2ui_pkg::KIND_KEY_UP;
            res_o.key_code   = key_xlat;
          end
        end
        ie2ui_pkg::TYPE_ABS: begin
          if (axis_x) begin
            cur_x_d = s1_i.ev_value;
          end else if (axis_y) begin
            cur_y_d = s1_i.ev_value;
          end
          if (pend_q == ie2ui_pkg::KIND_NONE) begin
            pend_d = ie2ui_pkg::KIND_MOUSE_MOVE;
          end
        end
        ie2ui_pkg::TYPE_REL: begin
          if (axis_x) begin
            cur_x_d = rel_sat;
          end else if (axis_y) begin
            cur_y_d = rel_sat;
          end
          if (pend_q == ie2ui_pkg::KIND_NONE) begin
            pend_d = ie2ui_pkg::KIND_MOUSE_MOVE;
          end
        end
        ie2ui_pkg::TYPE_SYNC: begin
          if (pend_q != ie2ui_pkg::KIND_NONE) begin
            cur_x_d          = $signed({16'd0, clamp_x});
            cur_y_d          = $signed({16'd0, clamp_y});
            pend_d           = ie2ui_pkg::KIND_NONE;
            res_vld_o        = 1'b1;
            res_o.event_kind = pend_q;
            res_o.pos_x      = clamp_x;
            res_o.pos_y      = clamp_y;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      pend_q  <= ie2ui_pkg::KIND_NONE;
    end else if (commit_i) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* src/input_event_to_ui_event_top.sv */
// ----------------------------------------------------------------------------
// input_event_to_ui_event_top: raw input event to UI event translator
// Non-button key events are remapped through a loadable key map; button and
// pointer events build a pending mouse event that sync clamps and emits.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake     | carries
//  ----------+-----+---------------+---------------------------------------
//  evt_i     | in  | valid/ready   | op, ev_type, ev_code, ev_value,
//            |     |               | map_index, map_value
//  ui_o      | out | valid/ready   | event_kind, key_code, pos_x, pos_y
//  cfg_*_i   | in  | write enable  | screen_width (0), screen_height (1)
//
//  One request per cycle sustained while the output is not stalled. At
//  accept the processing stage is loaded and the key map is read; when
//  the stage commits, cursor/pending state is updated and the output
//  register is loaded, from which ui_o presents the result.
//  Reset clears cursor, pending kind and the key map valid bits at once; no
//  clearing pass, the block takes requests right after reset.
//  A stalled output register freezes the processing stage; input ready
//  stays high while the processing stage is empty or retiring.
//
module input_event_to_ui_event_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  ie2ui_evt_if.sink           evt_i,
  ie2ui_ui_if.source          ui_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  // config registers
  logic [15:0] screen_w_q;
  logic [15:0] screen_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= ie2ui_pkg::SCREEN_W_RST;
      screen_h_q <= ie2ui_pkg::SCREEN_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ie2ui_pkg::CFG_SCREEN_W: screen_w_q <= cfg_wdata_i;
        ie2ui_pkg::CFG_SCREEN_H: screen_h_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // handshake / stage control
  logic            s1_vld_q;
  ie2ui_pkg::s1_t s1_q;
  logic            adv;        // output side can take the stage result
  logic            accept;
  logic            commit;
  logic            out_vld_q;
  ie2ui_pkg::res_t out_q;
  logic            res_vld;
  ie2ui_pkg::res_t res;

  assign adv         = !out_vld_q || ui_o.ready;
  assign evt_i.ready = !s1_vld_q || adv;
  assign accept      = evt_i.valid && evt_i.ready;
  assign commit      = s1_vld_q && adv;

  // key map access, issued at accept
  logic                          code_hit;
  logic                          map_wr;
  logic [ie2ui_pkg::MapIdxW-1:0] map_wr_idx;
  logic [ie2ui_pkg::MapIdxW-1:0] map_rd_idx;
  logic [15:0]                   map_data;

  assign code_hit   = (32'(evt_i.ev_code) < ie2ui_pkg::MAP_ENTRIES);
  assign map_wr     = accept && (evt_i.op == ie2ui_pkg::OP_MAP_WR) &&
                      (32'(evt_i.map_index) < ie2ui_pkg::MAP_ENTRIES);
  assign map_wr_idx = ie2ui_pkg::MapIdxW'(evt_i.map_index);
  assign map_rd_idx = ie2ui_pkg::MapIdxW'(evt_i.ev_code);

  // write lands at the accept edge, so a later read always sees it
  ie2ui_keymap u_keymap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (map_wr),
    .wr_idx_i  (map_wr_idx),
    .wr_data_i (evt_i.map_value),
    .rd_en_i   (accept),
    .rd_idx_i  (map_rd_idx),
    .rd_data_o (map_data)
  );

  // processing stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.op       <= evt_i.op;
      s1_q.ev_type  <= evt_i.ev_type;
      s1_q.ev_code  <= evt_i.ev_code;
      s1_q.ev_value <= evt_i.ev_value;
      s1_q.code_hit <= code_hit;
    end
  end

  ie2ui_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (commit),
    .s1_i       (s1_q),
    .map_data_i (map_data),
    .screen_w_i (screen_w_q),
    .screen_h_i (screen_h_q),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s1_vld_q && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && res_vld) begin
      out_q <= res;
    end
  end

  assign ui_o.valid      = out_vld_q;
  assign ui_o.event_kind = out_q.event_kind;
  assign ui_o.key_code   = out_q.key_code;
  assign ui_o.pos_x      = out_q.pos_x;
  assign ui_o.pos_y      = out_q.pos_y;

  // checks
  a_empty_stage_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_vld_q |-> evt_i.ready)
    else $error("input stalled with empty processing stage");

  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted request lost before processing");

  a_no_none_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.event_kind != ie2ui_pkg::KIND_NONE))
    else $error("result with no event kind");

  a_key_no_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ((out_q.event_kind == ie2ui_pkg::KIND_KEY_DOWN) ||
                   (out_q.event_kind == ie2ui_pkg::KIND_KEY_UP)))
      |-> (out_q.pos_x == 16'd0) && (out_q.pos_y == 16'd0))
    else $error("key event carries pointer position");

endmodule
